>>> rtl/pqft_pkg.sv
// ----------------------------------------------------------------------------
// pqft_pkg - shared types and constants of the stable priority queue
// Entry layout, response status codes, request codes, sequencer states and the default depth.
// ----------------------------------------------------------------------------
package pqft_pkg;

   localparam int PQFT_QUEUE_DEPTH = 16;

   // request codes
   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } pqft_status_type;

   // priority[33:32], seq[31:16], tag[15:0]
   typedef struct packed {
      logic [1:0]  prio;
      logic [15:0] seq;
      logic [15:0] tag;
   } pqft_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } pqft_state_type;

endpackage

>>> rtl/pqft_if.sv
// ----------------------------------------------------------------------------
// pqft_if - request and response channels of the stable priority queue
// Valid/ready channels; a request moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface pqft_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [1:0]  priority_level;
   logic [15:0] order_seq;
   logic [15:0] payload_tag;

   modport source (output valid, output req_type, output priority_level,
                   output order_seq, output payload_tag, input ready);
   modport sink   (input valid, input req_type, input priority_level,
                   input order_seq, input payload_tag, output ready);
endinterface

interface pqft_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_status;
   logic [1:0]  out_priority;
   logic [15:0] out_seq;
   logic [15:0] out_payload;
   logic [4:0]  fill_count;

   modport source (output valid, output result_status, output out_priority,
                   output out_seq, output out_payload, output fill_count,
                   input ready);
   modport sink   (input valid, input result_status, input out_priority,
                   input out_seq, input out_payload, input fill_count,
                   output ready);
endinterface

>>> rtl/pqft_store.sv
// ----------------------------------------------------------------------------
// pqft_store - entry memory of the stable priority queue
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pqft_store #(
   parameter  int DEPTH = pqft_pkg::PQFT_QUEUE_DEPTH,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  pqft_pkg::pqft_entry_type wr_data,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output pqft_pkg::pqft_entry_type rd_data
);
   import pqft_pkg::*;

   pqft_entry_type mem [DEPTH];
   pqft_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/priority_queue_fifo_tiebreak.sv
// ----------------------------------------------------------------------------
// priority_queue_fifo_tiebreak - stable priority queue
// Bounded queue: enqueue appends, dequeue removes the highest priority entry
// (smallest sequence number on ties, earliest slot after that) and closes
// the gap so arrival order is kept.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake        Carries
//   -------  ---------  ---------------  ------------------------------------
//   req_ch   in         valid / ready    req_type, priority_level, order_seq,
//                                        payload_tag
//   rsp_ch   out        valid / ready    result_status, out_priority, out_seq,
//                                        out_payload, fill_count
//
// An enqueue, a full enqueue or an empty dequeue has its response
// registered in the cycle after the request. A dequeue scans the held entries
// through the single read port and the shared compare, then the shift moves
// the entries behind the winner down one slot through the same read/write
// port pair; when the winner is the last entry nothing is moved.
// One request is in work at a time; req_ch.ready is low from acceptance until
// the response register can take the result.
// Reset (synchronous, active high) empties the queue at once; the memory is
// not cleared since only slots below the count are ever read.
// A stalled rsp_ch holds the response and blocks the next request.
// ----------------------------------------------------------------------------
module priority_queue_fifo_tiebreak #(
   parameter int QUEUE_DEPTH = pqft_pkg::PQFT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   pqft_req_if.sink    req_ch,
   pqft_rsp_if.source  rsp_ch
);
   import pqft_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // sequencer
   pqft_state_type   state_ff, state_in;

   // queue bookkeeping
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;          // next slot to read
   logic             pend_ff, pend_in;        // a read is in flight
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   pqft_entry_type   best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   pqft_status_type  rsp_status_ff, rsp_status_in;
   pqft_entry_type   rsp_entry_ff, rsp_entry_in;
   logic [4:0]       rsp_fill_ff, rsp_fill_in;

   // memory ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   pqft_entry_type   wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   pqft_entry_type   rd_data;

   logic             accept;
   logic             rsp_free;
   logic             is_full;
   logic             is_empty;
   logic             scan_more;
   logic             cand_better;
   pqft_entry_type   req_entry;
   logic [CNT_W-1:0] count_inc;
   logic [CNT_W-1:0] count_dec;
   logic [CNT_W+4:0] fill_cur_wide;
   logic [CNT_W+4:0] fill_inc_wide;
   logic [CNT_W+4:0] fill_dec_wide;

   pqft_store #(
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept       = req_ch.valid && req_ch.ready;

   assign is_full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign scan_more = (ptr_ff < count_ff);

   // shared compare: higher priority wins, then the smaller sequence number;
   // a full tie keeps the earlier slot
   assign cand_better = (rd_data.prio > best_ff.prio) ||
                        ((rd_data.prio == best_ff.prio) && (rd_data.seq < best_ff.seq));

   assign req_entry.prio = req_ch.priority_level;
   assign req_entry.seq  = req_ch.order_seq;
   assign req_entry.tag  = req_ch.payload_tag;

   assign count_inc = count_ff + CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);

   // fill_count shows the low five bits of the count
   assign fill_cur_wide = {5'd0, count_ff};
   assign fill_inc_wide = {5'd0, count_inc};
   assign fill_dec_wide = {5'd0, count_dec};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_ch.req_type == REQ_DEQUEUE) && !is_empty) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!scan_more && !pend_ff) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (!scan_more && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_fill_in   = rsp_fill_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = req_entry;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            ptr_in  = '0;
            pend_in = 1'b0;
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = '0;
               if (req_ch.req_type == REQ_ENQUEUE) begin
                  if (is_full) begin
                     // drop the entry
                     rsp_status_in = STATUS_FULL;
                     rsp_fill_in   = fill_cur_wide[4:0];
                  end else begin
                     wr_en         = 1'b1;
                     count_in      = count_inc;
                     rsp_status_in = STATUS_OK;
                     rsp_fill_in   = fill_inc_wide[4:0];
                  end
               end else if (is_empty) begin
                  rsp_status_in = STATUS_EMPTY;
                  rsp_fill_in   = fill_cur_wide[4:0];
               end else begin
                  // hold the response until the scan and shift are done
                  rsp_valid_in = 1'b0;
               end
            end
         end

         ST_SCAN: begin
            if (pend_ff) begin
               if ((pend_idx_ff == '0) || cand_better) begin
                  best_in     = rd_data;
                  best_idx_in = pend_idx_ff;
               end
            end
            if (scan_more) begin
               rd_en       = 1'b1;
               ptr_in      = ptr_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  // start the shift just behind the winner
                  ptr_in = CNT_W'(best_idx_ff) + CNT_W'(1);
               end
            end
         end

         ST_SHIFT: begin
            if (pend_ff) begin
               // move the entry read last cycle down by one slot
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - IDX_W'(1);
               wr_data = rd_data;
            end
            if (scan_more) begin
               rd_en       = 1'b1;
               ptr_in      = ptr_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
         end

         ST_DONE: begin
            if (rsp_free) begin
               count_in      = count_dec;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_entry_in  = best_ff;
               rsp_fill_in   = fill_dec_wide[4:0];
            end
         end

         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.result_status = rsp_status_ff;
   assign rsp_ch.out_priority  = rsp_entry_ff.prio;
   assign rsp_ch.out_seq       = rsp_entry_ff.seq;
   assign rsp_ch.out_payload   = rsp_entry_ff.tag;
   assign rsp_ch.fill_count    = rsp_fill_ff;

endmodule

>>> rtl/pqft_checker.sv
// ----------------------------------------------------------------------------
// pqft_checker - port-level assertions of the stable priority queue
// Watches the response channel: holds under stall, the fill bound, and status against payload and fill.
// ----------------------------------------------------------------------------
module pqft_checker #(
   parameter int QUEUE_DEPTH = pqft_pkg::PQFT_QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  result_status,
   input logic [1:0]  out_priority,
   input logic [15:0] out_seq,
   input logic [15:0] out_payload,
   input logic [4:0]  fill_count
);
   import pqft_pkg::*;

   // hold a response until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_status) && $stable(fill_count))
      else $error("response dropped or changed while stalled");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(fill_count) <= QUEUE_DEPTH)
      else $error("fill count above queue depth");

   a_empty_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (result_status == STATUS_EMPTY) |->
         (fill_count == 5'd0) && (out_priority == 2'd0) &&
         (out_seq == 16'd0) && (out_payload == 16'd0))
      else $error("empty response carries data or nonzero fill");

   a_full_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (result_status == STATUS_FULL) |->
         (fill_count == 5'(QUEUE_DEPTH)) && (out_priority == 2'd0) &&
         (out_seq == 16'd0) && (out_payload == 16'd0))
      else $error("full response with wrong fill or data");

endmodule

bind priority_queue_fifo_tiebreak pqft_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pqft_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .result_status (rsp_ch.result_status),
   .out_priority  (rsp_ch.out_priority),
   .out_seq       (rsp_ch.out_seq),
   .out_payload   (rsp_ch.out_payload),
   .fill_count    (rsp_ch.fill_count)
);

>>> test/tb_priority_queue_fifo_tiebreak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_queue_fifo_tiebreak - self-checking bench of the stable queue
// Drives enqueue and dequeue requests over the request channel and checks
// every response against a behavioral copy of the queue. It covers empty and
// full cases, priority and tie ordering, random traffic and response stalls.
// ----------------------------------------------------------------------------
module tb_priority_queue_fifo_tiebreak;
   import pqft_pkg::*;

   localparam int DEPTH          = PQFT_QUEUE_DEPTH;
   localparam int WATCHDOG_LIMIT = 2000;  // idle cycles before giving up
   localparam int DRAIN_CYCLES   = 64;    // longer than the worst dequeue
   localparam int LONG_HOLD      = 300;   // response stall of the pressure test
   localparam int RANDOM_ITEMS   = 1000;

   // response ready patterns
   localparam int RSP_ALWAYS  = 0;
   localparam int RSP_RANDOM  = 1;
   localparam int RSP_PATTERN = 2;

   typedef struct packed {
      logic        kind;
      logic [1:0]  prio;
      logic [15:0] seq;
      logic [15:0] tag;
   } queue_request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  prio;
      logic [15:0] seq;
      logic [15:0] tag;
      logic [4:0]  fill;
   } queue_reply_type;

   logic clock = 1'b0;
   logic reset;

   pqft_req_if req_bus ();
   pqft_rsp_if rsp_bus ();

   priority_queue_fifo_tiebreak #(
      .QUEUE_DEPTH (DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #2 clock = ~clock;

   // behavioral copy of the queue, in arrival order
   pqft_entry_type  held_entries [$];
   queue_reply_type pending_replies [$];
   int              error_count   = 0;
   int              request_count = 0;
   int              reply_count   = 0;

   // receiver controls, set by the tests
   int   rsp_mode      = RSP_ALWAYS;
   logic long_hold_req = 1'b0;

   // ------------------------------------------------------------------------
   // Predictor: apply one request to the queue copy and return its reply.
   // Enqueue appends behind the held entries unless the queue is full.
   // Dequeue picks the highest priority, then the smallest sequence number;
   // on a full tie the strict compare keeps the earliest slot. Deleting from
   // the SV queue closes the gap and keeps arrival order.
   // ------------------------------------------------------------------------
   function automatic queue_reply_type serve_request(input queue_request_type r);
      queue_reply_type reply;
      pqft_entry_type  best_entry;
      int              best;
      reply = '0;
      reply.status = STATUS_OK;
      if (r.kind == REQ_ENQUEUE) begin
         if (held_entries.size() >= DEPTH) begin
            reply.status = STATUS_FULL;
         end else begin
            held_entries.push_back('{prio: r.prio, seq: r.seq, tag: r.tag});
         end
      end else if (held_entries.size() == 0) begin
         reply.status = STATUS_EMPTY;
      end else begin
         best = 0;
         for (int i = 1; i < held_entries.size(); i++) begin
            if (held_entries[i].prio > held_entries[best].prio ||
                (held_entries[i].prio == held_entries[best].prio &&
                 held_entries[i].seq < held_entries[best].seq)) begin
               best = i;
            end
         end
         best_entry = held_entries[best];
         reply.prio = best_entry.prio;
         reply.seq  = best_entry.seq;
         reply.tag  = best_entry.tag;
         held_entries.delete(best);
      end
      reply.fill = 5'(held_entries.size());
      return reply;
   endfunction

   function automatic queue_request_type make_request(input logic kind,
                                                      input logic [1:0] prio,
                                                      input logic [15:0] seq,
                                                      input logic [15:0] tag);
      queue_request_type r;
      r.kind = kind;
      r.prio = prio;
      r.seq  = seq;
      r.tag  = tag;
      return r;
   endfunction

   // Random request; half of the sequence numbers come from a narrow range so
   // that ties on priority and sequence turn up often.
   function automatic queue_request_type random_request(input int enqueue_pct);
      queue_request_type r;
      r.kind = ($urandom_range(0, 99) < enqueue_pct) ? REQ_ENQUEUE : REQ_DEQUEUE;
      r.prio = 2'($urandom_range(0, 3));
      r.seq  = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom());
      r.tag  = 16'($urandom());
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Sender: drive one request at the falling edge and hold it until the
   // block takes it. Valid stays high on return, so a following call keeps
   // the burst going; idle_gap() drops it between bursts.
   // ------------------------------------------------------------------------
   task automatic send_request(input queue_request_type r);
      @(negedge clock);
      req_bus.valid          = 1'b1;
      req_bus.req_type       = r.kind;
      req_bus.priority_level = r.prio;
      req_bus.order_seq      = r.seq;
      req_bus.payload_tag    = r.tag;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_replies.push_back(serve_request(r));
      request_count++;
   endtask

   task automatic idle_gap(input int cycles);
      @(negedge clock);
      req_bus.valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // hold until every expected reply has come back
   task automatic wait_replies();
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: ready changes at the falling edge. A long hold requested by
   // the pressure test is counted here, then the current pattern resumes.
   // ------------------------------------------------------------------------
   initial begin
      int   hold_left;
      int   phase;
      logic hold_started;
      hold_left    = 0;
      phase        = 0;
      hold_started = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         phase++;
         if (long_hold_req && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            case (rsp_mode)
               RSP_RANDOM:  rsp_bus.ready = ($urandom_range(0, 3) != 0);
               RSP_PATTERN: rsp_bus.ready = (phase % 7 != 0) && (phase % 7 != 3);
               default:     rsp_bus.ready = 1'b1;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Checker: compare each accepted reply field by field with the oldest
   // expectation. A reply with nothing expected is a failure too.
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("ERROR at %0t: reply %0d %s = %0h, expected %0h",
               $realtime, reply_count, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      queue_reply_type got;
      queue_reply_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.status = rsp_bus.result_status;
         got.prio   = rsp_bus.out_priority;
         got.seq    = rsp_bus.out_seq;
         got.tag    = rsp_bus.out_payload;
         got.fill   = rsp_bus.fill_count;
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected reply, status", 16'(got.status), 16'h0);
         end else begin
            want = pending_replies.pop_front();
            if (got.status !== want.status)
               report_mismatch("result_status", 16'(got.status), 16'(want.status));
            if (got.prio !== want.prio)
               report_mismatch("out_priority", 16'(got.prio), 16'(want.prio));
            if (got.seq !== want.seq)
               report_mismatch("out_seq", got.seq, want.seq);
            if (got.tag !== want.tag)
               report_mismatch("out_payload", got.tag, want.tag);
            if (got.fill !== want.fill)
               report_mismatch("fill_count", 16'(got.fill), 16'(want.fill));
         end
         reply_count++;
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   int stall_cycles = 0;
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Dequeue on an empty queue, with every ignored field at all ones.
   task automatic test_empty_dequeue();
      send_request(make_request(REQ_DEQUEUE, 2'd3, 16'hFFFF, 16'hFFFF));
   endtask

   // Fill to the limit, then push once more: the extra entry is dropped.
   // The entries mix every priority, sequence extremes and several ties.
   task automatic test_fill_and_overflow();
      pqft_entry_type fill_entries [16];
      fill_entries = '{
         '{2'd3, 16'hFFFF, 16'h0001}, '{2'd0, 16'h0000, 16'hFFFF},
         '{2'd3, 16'h0005, 16'h0002}, '{2'd1, 16'h0000, 16'h0003},
         '{2'd3, 16'h0005, 16'h0004}, '{2'd2, 16'h8000, 16'h5555},
         '{2'd3, 16'h0000, 16'hAAAA}, '{2'd2, 16'h7FFF, 16'h0006},
         '{2'd1, 16'hFFFF, 16'h0007}, '{2'd0, 16'hFFFF, 16'h0000},
         '{2'd2, 16'h8000, 16'h0008}, '{2'd1, 16'h1234, 16'h0009},
         '{2'd3, 16'h0005, 16'h000A}, '{2'd0, 16'h0001, 16'h000B},
         '{2'd2, 16'h0001, 16'h000C}, '{2'd1, 16'h0001, 16'hFFFF}
      };
      for (int i = 0; i < DEPTH && i < 16; i++) begin
         send_request(make_request(REQ_ENQUEUE, fill_entries[i].prio,
                                   fill_entries[i].seq, fill_entries[i].tag));
      end
      send_request(make_request(REQ_ENQUEUE, 2'd3, 16'h0000, 16'hBEEF));
   endtask

   // Drain part of the full queue: the priority-3 group with its three-way
   // tie on sequence number comes out in slot order, then priority 2.
   task automatic test_tiebreak_drain();
      for (int i = 0; i < 7; i++) begin
         send_request(make_request(REQ_DEQUEUE, 2'($urandom_range(0, 3)),
                                   16'($urandom()), 16'($urandom())));
      end
      idle_gap(1);
      wait_replies();
   endtask

   // Random traffic in phases. The enqueue share swings so the queue runs
   // between empty and full; idling on both sides varies with the phase,
   // and every fourth phase runs without any gaps or stalls.
   task automatic test_random_traffic();
      int enqueue_shares [5];
      int burst_left;
      int phase;
      logic quiet;
      enqueue_shares = '{85, 15, 50, 70, 30};
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         phase = n / 100;
         quiet = (phase % 4 == 3);
         rsp_mode = quiet ? RSP_ALWAYS : (phase % 2 == 0 ? RSP_RANDOM : RSP_PATTERN);
         if (!quiet && burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
         end
         send_request(random_request(enqueue_shares[phase % 5]));
         if (burst_left > 0) burst_left--;
      end
      idle_gap(1);
      wait_replies();
   endtask

   // Pressure: stall the response side for a long stretch while requests
   // keep coming back to back, so the block holds its input off.
   task automatic test_output_backpressure();
      rsp_mode = RSP_ALWAYS;
      long_hold_req = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_request(random_request(60));
      end
      idle_gap(1);
      wait_replies();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.req_type       = REQ_ENQUEUE;
      req_bus.priority_level = 2'd0;
      req_bus.order_seq      = 16'h0;
      req_bus.payload_tag    = 16'h0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      test_empty_dequeue();
      test_fill_and_overflow();
      test_tiebreak_drain();
      test_random_traffic();
      test_output_backpressure();

      // let any stray reply show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/pqft_pkg.sv
rtl/pqft_if.sv
rtl/pqft_store.sv
rtl/priority_queue_fifo_tiebreak.sv
rtl/pqft_checker.sv
test/tb_priority_queue_fifo_tiebreak.sv
